/* rtl/core/bmmd_pkg.sv */
// Package with shared constants and types for the banked memory map decoder.
`timescale 1ns / 1ps

package bmmd_pkg;

    localparam int BASIC_BYTES   = 8192;
    localparam int KERNAL_BYTES  = 8192;
    localparam int CHARSET_BYTES = 4096;

    localparam int RAM_BYTES    = 65536;
    localparam int RAM_AW       = 16;
    localparam int COLOUR_BYTES = 1024;
    localparam int COLOUR_AW    = 10;

    localparam logic [3:0] COLOUR_RESET = 4'hE;
    localparam logic [3:0] COLOUR_UPPER = 4'hF;
    localparam logic [7:0] EXP_READ     = 8'hFF;

    typedef enum logic [1:0] {
        MODE_CPU_READ  = 2'd0,
        MODE_CPU_WRITE = 2'd1,
        MODE_VIDEO     = 2'd2,
        MODE_ROM_LOAD  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        TGT_RAM    = 4'd0,
        TGT_BASIC  = 4'd1,
        TGT_KERNAL = 4'd2,
        TGT_CHAR   = 4'd3,
        TGT_COLOUR = 4'd4,
        TGT_VIDEO  = 4'd5,
        TGT_SOUND  = 4'd6,
        TGT_TIMER1 = 4'd7,
        TGT_TIMER2 = 4'd8,
        TGT_EXP    = 4'd9,
        TGT_LOAD   = 4'd10
    } t_target;

    typedef enum logic [2:0] {
        DSRC_ZERO   = 3'd0,
        DSRC_RAM    = 3'd1,
        DSRC_BASIC  = 3'd2,
        DSRC_KERNAL = 3'd3,
        DSRC_CHAR   = 3'd4,
        DSRC_COLOUR = 3'd5,
        DSRC_ONES   = 3'd6
    } t_dsrc;

    typedef enum logic [1:0] {
        ROM_BASIC  = 2'd0,
        ROM_KERNAL = 2'd1,
        ROM_CHAR   = 2'd2
    } t_rom_sel;

    localparam logic [1:0] CFG_BASIC_PRESENT   = 2'd0;
    localparam logic [1:0] CFG_KERNAL_PRESENT  = 2'd1;
    localparam logic [1:0] CFG_CHARROM_PRESENT = 2'd2;

endpackage

/* rtl/core/banked_memory_map_decoder_top.sv */
// Top level of the banked memory map decoder with RAM, colour RAM and ROM stores.
`timescale 1ns / 1ps

// Channel   | Valid       | Stall        | Payload
// ----------+-------------+--------------+-----------------------------------------------
// access in | i_in_valid  | o_in_stall   | i_mode, i_address, i_write_data, i_cpu_port_*,
//           |             |              | i_video_bank, i_rom_select
// result    | o_out_valid | i_out_stall  | o_read_data, o_target, o_chip_offset,
//           |             |              | o_chip_write
// config    | i_cfg_we    | (none)       | i_cfg_index, i_cfg_data
//
// Each transaction is registered through the memory read registers into the result
// register, so one transaction is accepted per cycle while the result is taken.
// After reset a clearing pass zeroes every main RAM entry and sets colour RAM,
// one entry per cycle, and no transaction is accepted during it.
// A stalled result holds the result register and blocks the input channel.

module banked_memory_map_decoder_top #(
    parameter int BASIC_BYTES   = bmmd_pkg::BASIC_BYTES,
    parameter int KERNAL_BYTES  = bmmd_pkg::KERNAL_BYTES,
    parameter int CHARSET_BYTES = bmmd_pkg::CHARSET_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [2:0]  i_cpu_port_direction,
    input  logic [2:0]  i_cpu_port_value,
    input  logic [1:0]  i_video_bank,
    input  logic [1:0]  i_rom_select,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic [3:0]  o_target,
    output logic [5:0]  o_chip_offset,
    output logic        o_chip_write
);

    localparam int BASIC_AW   = $clog2(BASIC_BYTES);
    localparam int KERNAL_AW  = $clog2(KERNAL_BYTES);
    localparam int CHARSET_AW = $clog2(CHARSET_BYTES);
    localparam int RAM_AW     = bmmd_pkg::RAM_AW;
    localparam int COLOUR_AW  = bmmd_pkg::COLOUR_AW;

    logic [7:0] main_ram   [bmmd_pkg::RAM_BYTES];
    logic [3:0] colour_ram [bmmd_pkg::COLOUR_BYTES];
    logic [7:0] basic_mem  [BASIC_BYTES];
    logic [7:0] kernal_mem [KERNAL_BYTES];
    logic [7:0] char_mem   [CHARSET_BYTES];

    logic              r_basic_present;
    logic              r_kernal_present;
    logic              r_charrom_present;
    logic              r_clr_busy;
    logic [RAM_AW-1:0] r_clr_cnt;

    logic              r_valid;
    bmmd_pkg::t_target r_target;
    bmmd_pkg::t_dsrc   r_dsrc;
    logic [5:0]        r_offset;
    logic              r_chip_write;
    logic [7:0]        r_ram_q;
    logic [3:0]        r_col_q;
    logic [7:0]        r_basic_q;
    logic [7:0]        r_kernal_q;
    logic [7:0]        r_char_q;

    logic              accept;
    logic              take_out;
    bmmd_pkg::t_target n_target;
    bmmd_pkg::t_dsrc   n_dsrc;
    logic [5:0]        n_offset;
    logic              n_chip_write;
    logic              ram_we;
    logic              col_we;
    logic              basic_we;
    logic              kernal_we;
    logic              char_we;
    logic [RAM_AW-1:0] ram_raddr;

    logic [2:0] port_cfg;
    logic       lo;
    logic       hi;
    logic       ch;
    logic       io_on;
    logic       char_on;
    logic       in_io;
    logic [16:0] addr_ext;

    assign take_out   = r_valid && !i_out_stall;
    assign o_in_stall = r_clr_busy || (r_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    assign port_cfg = (i_cpu_port_value & i_cpu_port_direction) | ~i_cpu_port_direction;
    assign lo       = port_cfg[0];
    assign hi       = port_cfg[1];
    assign ch       = port_cfg[2];
    assign io_on    = ch && (lo || hi);
    assign char_on  = !ch && (lo || hi);
    assign in_io    = (i_address[15:12] == 4'hD);
    assign addr_ext = {1'b0, i_address};

    always_comb begin
        n_target     = bmmd_pkg::TGT_RAM;
        n_dsrc       = bmmd_pkg::DSRC_ZERO;
        n_offset     = '0;
        n_chip_write = 1'b0;
        ram_we       = 1'b0;
        col_we       = 1'b0;
        basic_we     = 1'b0;
        kernal_we    = 1'b0;
        char_we      = 1'b0;
        ram_raddr    = i_address;
        unique case (bmmd_pkg::t_mode'(i_mode))
            bmmd_pkg::MODE_CPU_READ: begin
                priority if (i_address[15:13] == 3'b101 && lo && hi && r_basic_present) begin
                    n_target = bmmd_pkg::TGT_BASIC;
                    n_dsrc   = bmmd_pkg::DSRC_BASIC;
                end else if (in_io && io_on) begin
                    unique case (i_address[11:10])
                        2'b00: begin
                            n_target = bmmd_pkg::TGT_VIDEO;
                            n_offset = i_address[5:0];
                        end
                        2'b01: begin
                            n_target = bmmd_pkg::TGT_SOUND;
                            n_offset = {1'b0, i_address[4:0]};
                        end
                        2'b10: begin
                            n_target = bmmd_pkg::TGT_COLOUR;
                            n_dsrc   = bmmd_pkg::DSRC_COLOUR;
                        end
                        default: begin
                            unique case (i_address[9:8])
                                2'b00: begin
                                    n_target = bmmd_pkg::TGT_TIMER1;
                                    n_offset = {2'b00, i_address[3:0]};
                                end
                                2'b01: begin
                                    n_target = bmmd_pkg::TGT_TIMER2;
                                    n_offset = {2'b00, i_address[3:0]};
                                end
                                default: begin
                                    n_target = bmmd_pkg::TGT_EXP;
                                    n_dsrc   = bmmd_pkg::DSRC_ONES;
                                end
                            endcase
                        end
                    endcase
                end else if (in_io && char_on && r_charrom_present) begin
                    n_target = bmmd_pkg::TGT_CHAR;
                    n_dsrc   = bmmd_pkg::DSRC_CHAR;
                end else if (i_address[15:13] == 3'b111 && hi && r_kernal_present) begin
                    n_target = bmmd_pkg::TGT_KERNAL;
                    n_dsrc   = bmmd_pkg::DSRC_KERNAL;
                end else begin
                    n_target = bmmd_pkg::TGT_RAM;
                    n_dsrc   = bmmd_pkg::DSRC_RAM;
                end
            end
            bmmd_pkg::MODE_CPU_WRITE: begin
                if (in_io && io_on) begin
                    unique case (i_address[11:10])
                        2'b00: begin
                            n_target     = bmmd_pkg::TGT_VIDEO;
                            n_offset     = i_address[5:0];
                            n_chip_write = 1'b1;
                        end
                        2'b01: begin
                            n_target     = bmmd_pkg::TGT_SOUND;
                            n_offset     = {1'b0, i_address[4:0]};
                            n_chip_write = 1'b1;
                        end
                        2'b10: begin
                            n_target = bmmd_pkg::TGT_COLOUR;
                            col_we   = 1'b1;
                        end
                        default: begin
                            unique case (i_address[9:8])
                                2'b00: begin
                                    n_target     = bmmd_pkg::TGT_TIMER1;
                                    n_offset     = {2'b00, i_address[3:0]};
                                    n_chip_write = 1'b1;
                                end
                                2'b01: begin
                                    n_target     = bmmd_pkg::TGT_TIMER2;
                                    n_offset     = {2'b00, i_address[3:0]};
                                    n_chip_write = 1'b1;
                                end
                                default: begin
                                    n_target = bmmd_pkg::TGT_EXP;
                                end
                            endcase
                        end
                    endcase
                end else begin
                    n_target = bmmd_pkg::TGT_RAM;
                    ram_we   = 1'b1;
                end
            end
            bmmd_pkg::MODE_VIDEO: begin
                ram_raddr = {i_video_bank, i_address[13:0]};
                if (i_address[13:12] == 2'b01 && !i_video_bank[0] && r_charrom_present) begin
                    n_target = bmmd_pkg::TGT_CHAR;
                    n_dsrc   = bmmd_pkg::DSRC_CHAR;
                end else begin
                    n_target = bmmd_pkg::TGT_RAM;
                    n_dsrc   = bmmd_pkg::DSRC_RAM;
                end
            end
            default: begin
                n_target  = bmmd_pkg::TGT_LOAD;
                basic_we  = (i_rom_select == bmmd_pkg::ROM_BASIC)
                            && (addr_ext < 17'(BASIC_BYTES));
                kernal_we = (i_rom_select == bmmd_pkg::ROM_KERNAL)
                            && (addr_ext < 17'(KERNAL_BYTES));
                char_we   = (i_rom_select == bmmd_pkg::ROM_CHAR)
                            && (addr_ext < 17'(CHARSET_BYTES));
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basic_present   <= 1'b0;
            r_kernal_present  <= 1'b0;
            r_charrom_present <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bmmd_pkg::CFG_BASIC_PRESENT:   r_basic_present   <= i_cfg_data;
                bmmd_pkg::CFG_KERNAL_PRESENT:  r_kernal_present  <= i_cfg_data;
                bmmd_pkg::CFG_CHARROM_PRESENT: r_charrom_present <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (&r_clr_cnt) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            main_ram[r_clr_cnt] <= 8'h00;
        end else if (accept && ram_we) begin
            main_ram[i_address] <= i_write_data;
        end
        if (accept) begin
            r_ram_q <= main_ram[ram_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            colour_ram[r_clr_cnt[COLOUR_AW-1:0]] <= bmmd_pkg::COLOUR_RESET;
        end else if (accept && col_we) begin
            colour_ram[i_address[COLOUR_AW-1:0]] <= i_write_data[3:0];
        end
        if (accept) begin
            r_col_q <= colour_ram[i_address[COLOUR_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && basic_we) begin
            basic_mem[i_address[BASIC_AW-1:0]] <= i_write_data;
        end
        if (accept) begin
            r_basic_q <= basic_mem[i_address[BASIC_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && kernal_we) begin
            kernal_mem[i_address[KERNAL_AW-1:0]] <= i_write_data;
        end
        if (accept) begin
            r_kernal_q <= kernal_mem[i_address[KERNAL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && char_we) begin
            char_mem[i_address[CHARSET_AW-1:0]] <= i_write_data;
        end
        if (accept) begin
            r_char_q <= char_mem[i_address[CHARSET_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (take_out) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_target     <= n_target;
            r_dsrc       <= n_dsrc;
            r_offset     <= n_offset;
            r_chip_write <= n_chip_write;
        end
    end

    always_comb begin
        unique case (r_dsrc)
            bmmd_pkg::DSRC_RAM:    o_read_data = r_ram_q;
            bmmd_pkg::DSRC_BASIC:  o_read_data = r_basic_q;
            bmmd_pkg::DSRC_KERNAL: o_read_data = r_kernal_q;
            bmmd_pkg::DSRC_CHAR:   o_read_data = r_char_q;
            bmmd_pkg::DSRC_COLOUR: o_read_data = {bmmd_pkg::COLOUR_UPPER, r_col_q};
            bmmd_pkg::DSRC_ONES:   o_read_data = bmmd_pkg::EXP_READ;
            default:               o_read_data = 8'h00;
        endcase
    end

    assign o_out_valid   = r_valid;
    assign o_target      = r_target;
    assign o_chip_offset = r_offset;
    assign o_chip_write  = r_chip_write;

endmodule
